/* sv/slsfr_pkg.sv */
// ----------------------------------------------------------------------------
// slsfr_pkg
// Shared types and constants for the sync-framed byte receiver.
// ----------------------------------------------------------------------------
package slsfr_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W       = $clog2(CAPACITY + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_REPLAY
    } back_state_t;

    // status == ST_DATA means replay len bytes from bank
    typedef struct packed {
        logic [1:0]       status;
        logic             bank;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

/* sv/slsfr_ram.sv */
// ----------------------------------------------------------------------------
// slsfr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module slsfr_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/slsfr_front.sv */
// ----------------------------------------------------------------------------
// slsfr_front
// Frame parser: sync hunt, length, payload store and checksum, issuing one
// command per frame into the command queue.
// ----------------------------------------------------------------------------
module slsfr_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      push,
    output slsfr_pkg::cmd_t           push_cmd,
    input  logic                      q_full,
    input  slsfr_pkg::bank_rel_t      rel,
    output logic                      mem_we,
    output logic [slsfr_pkg::ADDR_W:0] mem_waddr,
    output logic [7:0]                mem_wdata
);

    slsfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       wr_bank_reg, wr_bank_next;
    logic [1:0] bank_busy_reg, bank_busy_next;
    logic       accept;
    logic       store_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= slsfr_pkg::PH_HUNT1;
            frame_length_reg <= '0;
            bytes_seen_reg   <= '0;
            running_sum_reg  <= '0;
            wr_bank_reg      <= 1'b0;
            bank_busy_reg    <= '0;
        end else begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_sum_reg  <= running_sum_next;
            wr_bank_reg      <= wr_bank_next;
            bank_busy_reg    <= bank_busy_next;
        end
    end

    always_comb begin
        store_en = (phase_reg == slsfr_pkg::PH_PAYLOAD)
                && (frame_length_reg <= 8'(slsfr_pkg::CAPACITY))
                && (bytes_seen_reg < 8'(slsfr_pkg::CAPACITY));
        s_ready  = !((phase_reg == slsfr_pkg::PH_CHECK) && q_full)
                && !(store_en && bank_busy_reg[wr_bank_reg]);
        accept   = s_valid && s_ready;

        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_sum_next  = running_sum_reg;
        wr_bank_next      = wr_bank_reg;
        push              = 1'b0;
        push_cmd.status   = slsfr_pkg::ST_DATA;
        push_cmd.bank     = wr_bank_reg;
        push_cmd.len      = frame_length_reg[slsfr_pkg::LEN_W-1:0];
        mem_we            = 1'b0;
        mem_waddr         = {wr_bank_reg, bytes_seen_reg[slsfr_pkg::ADDR_W-1:0]};
        mem_wdata         = s_rx_byte;

        if (accept) begin
            unique case (phase_reg)
                slsfr_pkg::PH_HUNT1: begin
                    if (s_rx_byte == slsfr_pkg::SYNC_FIRST) begin
                        phase_next = slsfr_pkg::PH_HUNT2;
                    end
                end
                slsfr_pkg::PH_HUNT2: begin
                    phase_next = (s_rx_byte == slsfr_pkg::SYNC_SECOND)
                               ? slsfr_pkg::PH_LENGTH : slsfr_pkg::PH_HUNT1;
                end
                slsfr_pkg::PH_LENGTH: begin
                    frame_length_next = s_rx_byte;
                    bytes_seen_next   = '0;
                    running_sum_next  = '0;
                    phase_next = (s_rx_byte == 8'd0)
                               ? slsfr_pkg::PH_CHECK : slsfr_pkg::PH_PAYLOAD;
                end
                slsfr_pkg::PH_PAYLOAD: begin
                    mem_we           = store_en;
                    running_sum_next = running_sum_reg + s_rx_byte;
                    bytes_seen_next  = bytes_seen_reg + 8'd1;
                    if (bytes_seen_next >= frame_length_reg) begin
                        phase_next = slsfr_pkg::PH_CHECK;
                    end
                end
                slsfr_pkg::PH_CHECK: begin
                    push = 1'b1;
                    priority if (frame_length_reg > 8'(slsfr_pkg::CAPACITY)) begin
                        push_cmd.status = slsfr_pkg::ST_TOO_LONG;
                    end else if (running_sum_reg != s_rx_byte) begin
                        push_cmd.status = slsfr_pkg::ST_BAD_SUM;
                    end else if (frame_length_reg == 8'd0) begin
                        push_cmd.status = slsfr_pkg::ST_EMPTY;
                    end else begin
                        push_cmd.status = slsfr_pkg::ST_DATA;
                        wr_bank_next    = !wr_bank_reg;
                    end
                    phase_next = slsfr_pkg::PH_HUNT1;
                end
                default: begin
                    phase_next = slsfr_pkg::PH_HUNT1;
                end
            endcase
        end

        bank_busy_next = bank_busy_reg;
        if (rel.valid) begin
            bank_busy_next[rel.bank] = 1'b0;
        end
        if (push && (push_cmd.status == slsfr_pkg::ST_DATA)) begin
            bank_busy_next[wr_bank_reg] = 1'b1;
        end
    end

endmodule

/* sv/slsfr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// slsfr_cmd_fifo
// Short command queue between the frame parser and the replay engine.
// ----------------------------------------------------------------------------
module slsfr_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slsfr_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output slsfr_pkg::cmd_t pop_cmd,
    output logic            empty
);

    localparam int PTR_W = (slsfr_pkg::QUEUE_DEPTH > 1) ? $clog2(slsfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(slsfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(slsfr_pkg::QUEUE_DEPTH - 1);

    slsfr_pkg::cmd_t   entry_reg [slsfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    always_comb begin
        full    = (count_reg == CNT_W'(slsfr_pkg::QUEUE_DEPTH));
        empty   = (count_reg == '0);
        do_push = push && !full;
        do_pop  = pop && !empty;
        pop_cmd = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/slsfr_back.sv */
// ----------------------------------------------------------------------------
// slsfr_back
// Replay engine: turns queued commands into results, reading payload bytes
// from the RAM one per cycle, when not stalled, into the output register.
// ----------------------------------------------------------------------------
module slsfr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  slsfr_pkg::cmd_t            q_cmd,
    output logic                       q_pop,
    output slsfr_pkg::bank_rel_t       rel,
    output logic                       mem_re,
    output logic [slsfr_pkg::ADDR_W:0] mem_raddr,
    input  logic [7:0]                 mem_rdata,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_data_byte,
    output logic                       m_last,
    output logic [1:0]                 m_status
);

    slsfr_pkg::back_state_t state_reg, state_next;
    logic [slsfr_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [slsfr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                         bank_reg, bank_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_last_reg, s1_last_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_data_byte_reg, m_data_byte_next;
    logic                         m_last_reg, m_last_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic                         out_free;
    logic                         is_last_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= slsfr_pkg::BK_IDLE;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        len_reg         <= len_next;
        bank_reg        <= bank_next;
        s1_last_reg     <= s1_last_next;
        m_data_byte_reg <= m_data_byte_next;
        m_last_reg      <= m_last_next;
        m_status_reg    <= m_status_next;
    end

    always_comb begin
        out_free    = !m_valid_reg || m_ready;
        is_last_idx = (slsfr_pkg::LEN_W'(idx_reg) + slsfr_pkg::LEN_W'(1)) == len_reg;

        state_next       = state_reg;
        idx_next         = idx_reg;
        len_next         = len_reg;
        bank_next        = bank_reg;
        s1_valid_next    = s1_valid_reg;
        s1_last_next     = s1_last_reg;
        m_valid_next     = m_valid_reg;
        m_data_byte_next = m_data_byte_reg;
        m_last_next      = m_last_reg;
        m_status_next    = m_status_reg;
        q_pop            = 1'b0;
        rel.valid        = 1'b0;
        rel.bank         = bank_reg;
        mem_re           = 1'b0;
        mem_raddr        = {bank_reg, idx_reg};

        if (out_free) begin
            m_valid_next = 1'b0;
        end

        // read stage to output register
        if (out_free && s1_valid_reg) begin
            m_valid_next     = 1'b1;
            m_data_byte_next = mem_rdata;
            m_last_next      = s1_last_reg;
            m_status_next    = slsfr_pkg::ST_DATA;
            s1_valid_next    = 1'b0;
        end

        unique case (state_reg)
            slsfr_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    if (q_cmd.status == slsfr_pkg::ST_DATA) begin
                        q_pop      = 1'b1;
                        idx_next   = '0;
                        len_next   = q_cmd.len;
                        bank_next  = q_cmd.bank;
                        state_next = slsfr_pkg::BK_REPLAY;
                    end else if (out_free && !s1_valid_reg) begin
                        q_pop            = 1'b1;
                        m_valid_next     = 1'b1;
                        m_data_byte_next = '0;
                        m_last_next      = 1'b1;
                        m_status_next    = q_cmd.status;
                    end
                end
            end
            slsfr_pkg::BK_REPLAY: begin
                if (!s1_valid_reg || out_free) begin
                    mem_re        = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_last_next  = is_last_idx;
                    idx_next      = idx_reg + slsfr_pkg::ADDR_W'(1);
                    if (is_last_idx) begin
                        rel.valid  = 1'b1;
                        state_next = slsfr_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = slsfr_pkg::BK_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_data_byte = m_data_byte_reg;
    assign m_last      = m_last_reg;
    assign m_status    = m_status_reg;

endmodule

/* sv/sync_length_sum_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver
// Sync-framed byte receiver with length byte and 8-bit additive checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, one per cycle unless held off.
// The parser hunts for 0xAA 0x55, reads a length byte, stores up to 64
// payload bytes into one of two RAM banks and checks the checksum byte
// against the 8-bit payload sum. Each frame leaves one command in a
// two-entry queue. A good frame replays its payload one byte per cycle when
// not stalled, the first byte passing the queue, the replay state, the RAM
// read and output registers; a bad checksum, an over-long length or an empty
// frame gives a single status result. Input is held off only when the queue
// is full at a checksum byte, or when a payload byte is due for a bank whose
// previous frame is still queued or replaying, so a payload byte can wait for
// one whole replay of up to 64 bytes while results are taken every cycle, and
// longer under output back-pressure. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last,
    output logic [1:0] m_status
);

    slsfr_pkg::cmd_t       push_cmd;
    slsfr_pkg::cmd_t       pop_cmd;
    slsfr_pkg::bank_rel_t  rel;
    logic                  push, q_full, q_pop, q_empty;
    logic                  mem_we, mem_re;
    logic [slsfr_pkg::ADDR_W:0] mem_waddr, mem_raddr;
    logic [7:0]            mem_wdata, mem_rdata;

    slsfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full),
        .rel       (rel),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    slsfr_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    slsfr_ram #(
        .DATA_W (8),
        .ADDR_W (slsfr_pkg::ADDR_W + 1)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    slsfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .rel         (rel),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_last      (m_last),
        .m_status    (m_status)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("command pushed into full queue");

    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != slsfr_pkg::ST_DATA)) |-> (m_last && (m_data_byte == 8'd0)))
        else $error("status result with data or without last");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr[slsfr_pkg::ADDR_W] != mem_raddr[slsfr_pkg::ADDR_W]))
        else $error("payload write into bank under replay");

    a_idle_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");
`endif

endmodule
